### src/ssq_pkg.sv
// ssq_pkg: shared types and codes for the stable sorted process queue.
// Used by ssq_cell and stable_sorted_process_queue; no dependencies.
package ssq_pkg;

    localparam int IdW  = 8;
    localparam int KeyW = 16;

    typedef logic [IdW-1:0]  t_id;
    typedef logic [KeyW-1:0] t_key;

    typedef enum logic [1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_PEEK = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_id  id;
        t_key key;
    } t_entry;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic   ins;
        logic   deq;
        logic   sorted;
        t_entry item;
    } t_cmd;

endpackage

### src/stable_sorted_process_queue.sv
// stable_sorted_process_queue: top level; a row of ssq_cell slots with the
// fill count, mode register and output register. Depends on ssq_pkg, ssq_cell.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle unless stalled; all slots compare and shift in the
// same cycle, so the cell row's key compare plus the slot-select chain sets the clock.
// Reset (sync, active low) clears the fill count, sort mode and output valid;
// slot contents are not cleared and slots past the fill count are never read.
module stable_sorted_process_queue
    import ssq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_proc_id,
    input  logic [15:0] i_sort_key,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_head_id,
    output logic [15:0] o_head_key,
    output logic [1:0]  o_status,
    output logic        o_now_empty,
    output logic [4:0]  o_entry_count
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    logic            r_mode;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic            r_vld;
    t_entry          r_head;
    t_status         r_status;

    logic            w_accept;
    logic            w_empty;
    logic            w_full;
    t_req            w_req;
    t_cmd            w_cmd;
    t_entry          n_head;
    t_status         n_status;

    t_entry                 w_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]   w_suffix;
    logic [QUEUE_DEPTH-1:0] w_prev;
    logic [QUEUE_DEPTH-1:0] w_occ;
    logic [CntW+4:0]        w_count_ext;

    assign o_ready  = !r_vld || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_req    = t_req'(i_req_type);
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == CntW'(QUEUE_DEPTH));

    assign w_cmd.ins      = w_accept && (w_req == REQ_ENQ) && !w_full;
    assign w_cmd.deq      = w_accept && (w_req == REQ_DEQ) && !w_empty;
    assign w_cmd.sorted   = r_mode;
    assign w_cmd.item.id  = i_proc_id;
    assign w_cmd.item.key = i_sort_key;

    assign w_suffix[QUEUE_DEPTH] = 1'b0;
    assign w_prev = {w_suffix[QUEUE_DEPTH-2:0], 1'b1};

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_l;
        t_entry w_r;

        assign w_occ[g] = (CntW'(g) < r_count);

        if (g == 0) begin : g_first
            assign w_l = w_entry[g];
        end else begin : g_mid_l
            assign w_l = w_entry[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_r = w_entry[g];
        end else begin : g_mid_r
            assign w_r = w_entry[g+1];
        end

        ssq_cell u_cell (
            .i_clk          (i_clk),
            .i_cmd          (w_cmd),
            .i_occ          (w_occ[g]),
            .i_prev_suffix  (w_prev[g]),
            .i_suffix_right (w_suffix[g+1]),
            .i_left         (w_l),
            .i_right        (w_r),
            .o_suffix       (w_suffix[g]),
            .o_entry        (w_entry[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_head   = '0;
        n_status = ST_OK;
        case (w_req)
            REQ_ENQ: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CntW'(1);
                end
            end
            REQ_DEQ, REQ_PEEK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head = w_entry[0];
                    if (w_req == REQ_DEQ) begin
                        n_count = r_count - CntW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_count <= '0;
            r_vld   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_count <= n_count;
                r_vld   <= 1'b1;
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_head   <= n_head;
            r_status <= n_status;
        end
    end

    // result count reported in 5 bits
    assign w_count_ext   = {5'b0, r_count};
    assign o_valid       = r_vld;
    assign o_head_id     = r_head.id;
    assign o_head_key    = r_head.key;
    assign o_status      = r_status;
    assign o_now_empty   = w_empty;
    assign o_entry_count = w_count_ext[4:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(QUEUE_DEPTH))
        else $error("fill count above depth");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> r_count == $past(r_count) + CntW'(1))
        else $error("enqueue did not raise fill count");

    a_deq_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.deq |=> (o_head_id == $past(w_entry[0].id))
                      && (o_head_key == $past(w_entry[0].key)))
        else $error("dequeue reported wrong head");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_empty && (w_req == REQ_DEQ || w_req == REQ_PEEK)
        |=> o_valid && (o_status == ST_EMPTY) && o_now_empty)
        else $error("empty read not flagged");

endmodule

### src/ssq_cell.sv
// ssq_cell: one slot of the queue row; holds an entry and shifts it to or
// from its neighbors on insert and dequeue. Depends on ssq_pkg.
module ssq_cell
    import ssq_pkg::*;
(
    input  logic   i_clk,
    input  t_cmd   i_cmd,
    input  logic   i_occ,          // slot holds a live entry
    input  logic   i_prev_suffix,  // some slot at or right of the left neighbor is <= key
    input  logic   i_suffix_right, // some slot right of this one is <= key
    input  t_entry i_left,
    input  t_entry i_right,
    output logic   o_suffix,
    output t_entry o_entry
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_le;

    // in FIFO mode every live slot counts as "not greater", so the new item lands at the tail
    assign w_le     = i_occ && (!i_cmd.sorted || (r_entry.key <= i_cmd.item.key));
    assign o_suffix = w_le || i_suffix_right;
    assign o_entry  = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (!i_prev_suffix) begin
                n_entry = i_left;
            end else if (!o_suffix) begin
                n_entry = i_cmd.item;
            end
        end else if (i_cmd.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
